[sv/cfv_pkg.sv]
// cfv_pkg: shared types and constants for the causal fir vector filter
// word layouts, register indexes, command codes and controller/datapath links
// no dependencies
package cfv_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int FRAC_BITS      = SAMPLE_BITS - 1;
   localparam int MAX_TAPS_DEF   = 64;
   localparam int TAP_IDX_BITS   = 6;
   localparam int TAP_COUNT_BITS = 7;
   localparam int VEC_LEN_BITS   = 16;
   localparam int CSR_IDX_BITS   = 2;
   localparam int CSR_DATA_BITS  = 16;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_TAP_COUNT     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_VECTOR_LENGTH = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_COMPLEX_MODE  = 2'd2;

   // word commands
   localparam logic CMD_TAP    = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef struct packed {
      logic                          cmd;
      logic [TAP_IDX_BITS-1:0]       tap_index;
      logic signed [SAMPLE_BITS-1:0] value_re;
      logic signed [SAMPLE_BITS-1:0] value_im;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_re;
      logic signed [SAMPLE_BITS-1:0] out_im;
      logic                          last_in_vector;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic tap_wr;
      logic sample_start;
      logic issue;
      logic result_load;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic issue_done;
      logic pipe_busy;
   } dp_status_type;

endpackage

[sv/cfv_ctrl.sv]
// cfv_ctrl: sequencing state machine for the causal fir vector filter
// drives the input stall, the result valid and the datapath commands
// depends on cfv_pkg
module cfv_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_cmd,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  cfv_pkg::dp_status_type status,
   output cfv_pkg::ctrl_cmd_type  cmd
);
   import cfv_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       slot_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in         = state_ff;
      cmd.tap_wr       = 1'b0;
      cmd.sample_start = 1'b0;
      cmd.issue        = 1'b0;
      cmd.result_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_cmd == CMD_TAP) begin
               cmd.tap_wr = 1'b1;
            end else if (accept && req_cmd == CMD_SAMPLE) begin
               cmd.sample_start = 1'b1;
               state_in         = S_RUN;
            end
         end
         S_RUN: begin
            cmd.issue = !status.issue_done;
            if (status.issue_done && !status.pipe_busy) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               cmd.result_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[sv/cfv_datapath.sv]
// cfv_datapath: tap and history memories, complex multiply-accumulate pipe,
// rounding and saturation, result register and control registers
// depends on cfv_pkg
module cfv_datapath #(
   parameter int MAX_TAPS = cfv_pkg::MAX_TAPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cfv_pkg::req_word_type              req_data,
   input  logic                               csr_write_en,
   input  logic [cfv_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [cfv_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  cfv_pkg::ctrl_cmd_type              cmd,
   output cfv_pkg::dp_status_type             status,
   output cfv_pkg::rsp_word_type              rsp_data
);
   import cfv_pkg::*;

   localparam int AW        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int TAP_LIMIT = (MAX_TAPS < 127) ? MAX_TAPS : 127;
   localparam int SB        = SAMPLE_BITS;
   localparam int PROD_W    = 2 * SB;
   localparam int ACC_W     = 2 * SB + AW + 2;
   localparam int SH_W      = ACC_W - FRAC_BITS;
   localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_TAPS - 1);
   localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [SB-1:0] SAT_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SAT_MIN = {1'b1, {(SB-1){1'b0}}};

   // control registers
   logic [TAP_COUNT_BITS-1:0] tap_count_ff;
   logic [VEC_LEN_BITS-1:0]   vector_length_ff;
   logic                      complex_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff     <= TAP_COUNT_BITS'(1);
         vector_length_ff <= VEC_LEN_BITS'(1);
         complex_mode_ff  <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_TAP_COUNT:     tap_count_ff     <= csr_wdata[TAP_COUNT_BITS-1:0];
            REG_VECTOR_LENGTH: vector_length_ff <= csr_wdata[VEC_LEN_BITS-1:0];
            REG_COMPLEX_MODE:  complex_mode_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // vector tracking
   logic [VEC_LEN_BITS-1:0]   pos_ff, pos_in;
   logic [AW-1:0]             head_ff, head_in;
   logic [VEC_LEN_BITS:0]     pos_next;
   logic [VEC_LEN_BITS:0]     len_eff;
   logic                      is_last;
   logic [TAP_COUNT_BITS-1:0] taps_used;

   assign pos_next  = {1'b0, pos_ff} + (VEC_LEN_BITS+1)'(1);
   assign len_eff   = (vector_length_ff == '0) ? {1'b1, {VEC_LEN_BITS{1'b0}}}
                                               : {1'b0, vector_length_ff};
   assign is_last   = (pos_next >= len_eff);
   assign taps_used = (tap_count_ff > TAP_COUNT_BITS'(TAP_LIMIT))
                      ? TAP_COUNT_BITS'(TAP_LIMIT) : tap_count_ff;

   always_comb begin
      pos_in  = pos_ff;
      head_in = head_ff;
      if (cmd.sample_start) begin
         if (is_last) begin
            pos_in  = '0;
            head_in = '0;
         end else begin
            pos_in  = pos_next[VEC_LEN_BITS-1:0];
            head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);
         end
      end
   end

   // per-sample context
   logic [VEC_LEN_BITS-1:0]   cur_pos_ff;
   logic                      cur_last_ff;
   logic                      cur_cplx_ff;
   logic [AW-1:0]             k_ff, k_in;
   logic [AW-1:0]             slot_ff, slot_in;
   logic [TAP_COUNT_BITS-1:0] left_ff, left_in;

   always_comb begin
      k_in    = k_ff;
      slot_in = slot_ff;
      left_in = left_ff;
      if (cmd.sample_start) begin
         k_in    = '0;
         slot_in = head_ff;
         left_in = taps_used;
      end else if (cmd.issue) begin
         k_in    = k_ff + AW'(1);
         slot_in = (slot_ff == '0) ? LAST_SLOT : slot_ff - AW'(1);
         left_in = left_ff - TAP_COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         head_ff <= '0;
         left_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         head_ff <= head_in;
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      slot_ff <= slot_in;
      if (cmd.sample_start) begin
         cur_pos_ff  <= pos_ff;
         cur_last_ff <= is_last;
         cur_cplx_ff <= complex_mode_ff;
      end
   end

   // memories, registered reads
   logic [2*SB-1:0] coef_mem [MAX_TAPS];
   logic [2*SB-1:0] hist_mem [MAX_TAPS];
   logic [2*SB-1:0] coef_rd_ff;
   logic [2*SB-1:0] hist_rd_ff;
   logic            tap_wr_ok;
   logic [SB-1:0]   sample_im;

   assign tap_wr_ok = (32'(req_data.tap_index) < 32'(MAX_TAPS));
   assign sample_im = complex_mode_ff ? req_data.value_im : '0;

   always_ff @(posedge clock) begin
      if (cmd.tap_wr && tap_wr_ok) begin
         coef_mem[AW'(req_data.tap_index)] <= {req_data.value_re, req_data.value_im};
      end
      if (cmd.issue) begin
         coef_rd_ff <= coef_mem[k_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sample_start) begin
         hist_mem[head_ff] <= {req_data.value_re, sample_im};
      end
      if (cmd.issue) begin
         hist_rd_ff <= hist_mem[slot_ff];
      end
   end

   // pipe: read, multiply, accumulate
   logic v1_ff, v2_ff;
   logic z1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
      end
   end

   // taps reaching before the vector start see zero samples
   always_ff @(posedge clock) begin
      z1_ff <= (VEC_LEN_BITS'(k_ff) > cur_pos_ff);
   end

   logic signed [SB-1:0] br, bi, xr, xi;
   logic signed [PROD_W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;

   assign br = coef_rd_ff[2*SB-1:SB];
   assign bi = cur_cplx_ff ? coef_rd_ff[SB-1:0] : '0;
   assign xr = z1_ff ? '0 : hist_rd_ff[2*SB-1:SB];
   assign xi = z1_ff ? '0 : hist_rd_ff[SB-1:0];

   always_ff @(posedge clock) begin
      p_rr_ff <= br * xr;
      p_ii_ff <= bi * xi;
      p_ri_ff <= br * xi;
      p_ir_ff <= bi * xr;
   end

   logic signed [ACC_W-1:0] acc_re_ff, acc_re_in;
   logic signed [ACC_W-1:0] acc_im_ff, acc_im_in;

   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (cmd.sample_start) begin
         acc_re_in = '0;
         acc_im_in = '0;
      end else if (v2_ff) begin
         acc_re_in = acc_re_ff + ACC_W'(p_rr_ff) - ACC_W'(p_ii_ff);
         acc_im_in = acc_im_ff + ACC_W'(p_ri_ff) + ACC_W'(p_ir_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
   end

   assign status.issue_done = (left_ff == '0);
   assign status.pipe_busy  = v1_ff || v2_ff;

   // round half up, then saturate
   function automatic logic signed [SB-1:0] round_sat(input logic signed [ACC_W-1:0] a);
      logic [ACC_W-1:0]       sum;
      logic signed [SH_W-1:0] q;
      logic                   fits;
      sum  = a + HALF_LSB;
      q    = sum[ACC_W-1:FRAC_BITS];
      fits = (&q[SH_W-1:SB-1]) || !(|q[SH_W-1:SB-1]);
      if (fits) begin
         round_sat = q[SB-1:0];
      end else begin
         round_sat = q[SH_W-1] ? SAT_MIN : SAT_MAX;
      end
   endfunction

   rsp_word_type rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_ff.out_re         <= round_sat(acc_re_ff);
         rsp_ff.out_im         <= cur_cplx_ff ? round_sat(acc_im_ff) : '0;
         rsp_ff.last_in_vector <= cur_last_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[sv/causal_fir_vector_filter.sv]
// causal_fir_vector_filter: top level of the causal fir vector filter
// joins the controller (cfv_ctrl) and the datapath (cfv_datapath)
// depends on cfv_pkg
//
//   channel | ports                               | direction
//   --------+-------------------------------------+-----------------------------
//   req     | req_valid, req_stall, req_data      | in: tap writes and samples
//   rsp     | rsp_valid, rsp_stall, rsp_data      | out: one word per sample
//   csr     | csr_write_en, csr_index, csr_wdata  | in: register writes
//
// a sample walks min(tap_count, MAX_TAPS) taps, none with a zero tap count, through
// the single complex multiply-accumulate, one a cycle
// reset is synchronous and active high; taps are undefined until written and
// history is masked by position in the vector, so no clearing pass
// a finished word waits in the output register while the next word is taken;
// the finish state holds only while that register is still full and stalled
module causal_fir_vector_filter #(
   parameter int MAX_TAPS = cfv_pkg::MAX_TAPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  cfv_pkg::req_word_type             req_data,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cfv_pkg::rsp_word_type             rsp_data,
   // register writes
   input  logic                              csr_write_en,
   input  logic [cfv_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [cfv_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import cfv_pkg::*;

   // command and status between the two halves
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer: accepts words, walks the taps, loads the output register
   cfv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // memories, mac pipe, rounding and the result register
   cfv_datapath #(
      .MAX_TAPS (MAX_TAPS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_data     (rsp_data)
   );

endmodule

[tb/sv/causal_fir_vector_filter_tb.sv]
`timescale 1ns / 1ps
// causal_fir_vector_filter_tb: self-checking bench for the causal fir vector filter
// drives tap writes, samples and register writes, predicts every filtered word
// depends on cfv_pkg and causal_fir_vector_filter
module causal_fir_vector_filter_tb;
   import cfv_pkg::*;

   localparam int MAX_TAPS = MAX_TAPS_DEF;
   // index past the register list, writes to it must change nothing
   localparam logic [CSR_IDX_BITS-1:0] REG_UNUSED = 2'd3;
   // percent of cycles in which each side idles
   localparam int IDLE_PCT = 38;
   // cycles to let the block settle once nothing is expected any more
   localparam int SETTLE_CYCLES = 80;
   // receiver hold-off that fills the block and backs up the request side
   localparam int HOLD_CYCLES = 400;
   localparam int WORD_TARGET = 550;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic                     csr_write_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index    = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata    = '0;

   // stimulus and scoreboard
   req_word_type pending_words[$];
   rsp_word_type expected_outputs[$];
   int  words_queued   = 0;
   int  mismatch_count = 0;
   logic req_taken     = 1'b0;

   // idling controls, owned by the stimulus process
   bit calm       = 1'b0;
   bit hold_phase = 1'b0;
   // owned by the receiver process
   int hold_left  = 0;
   bit hold_used  = 1'b0;

   // filter mirror: registers, taps, sample ring and vector position
   logic [TAP_COUNT_BITS-1:0]     taps_cfg   = 7'd1;
   logic [VEC_LEN_BITS-1:0]       length_cfg = 16'd1;
   logic                          cplx_cfg   = 1'b0;
   logic signed [SAMPLE_BITS-1:0] tap_re  [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] tap_im  [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] hist_re [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] hist_im [MAX_TAPS];
   logic [TAP_IDX_BITS-1:0]       hist_head    = '0;
   int                            vec_position = 0;

   causal_fir_vector_filter u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // round to nearest with halves going up, then clamp to q1.15
   function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input longint acc);
      longint r;
      r = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r > 32767)
         return 16'sh7FFF;
      if (r < -32768)
         return 16'sh8000;
      return r[SAMPLE_BITS-1:0];
   endfunction

   function automatic void clear_history();
      for (int i = 0; i < MAX_TAPS; i++) begin
         hist_re[i] = '0;
         hist_im[i] = '0;
      end
      hist_head    = '0;
      vec_position = 0;
   endfunction

   // advance the mirror by one request word; returns 1 when a filtered word results
   function automatic bit filter_word(input req_word_type w, output rsp_word_type y);
      longint acc_re, acc_im, br, bi, xr, xi;
      int taps, vlen, k;
      logic [TAP_IDX_BITS-1:0] slot;
      y = '0;
      if (w.cmd == CMD_TAP) begin
         tap_re[w.tap_index] = w.value_re;
         tap_im[w.tap_index] = w.value_im;
         return 1'b0;
      end
      // real mode drops the imaginary part of the sample
      hist_re[hist_head] = w.value_re;
      hist_im[hist_head] = cplx_cfg ? w.value_im : '0;
      taps   = (taps_cfg > MAX_TAPS) ? MAX_TAPS : int'(taps_cfg);
      acc_re = 0;
      acc_im = 0;
      for (k = 0; k < taps; k++) begin
         slot = hist_head - TAP_IDX_BITS'(k);
         br = tap_re[k];
         bi = cplx_cfg ? longint'(tap_im[k]) : 0;
         xr = hist_re[slot];
         xi = hist_im[slot];
         acc_re += br * xr - bi * xi;
         acc_im += br * xi + bi * xr;
      end
      y.out_re = round_sat(acc_re);
      y.out_im = cplx_cfg ? round_sat(acc_im) : '0;
      hist_head = hist_head + 1'b1;
      // a zero length stands for a full 65536-sample vector
      vlen = (length_cfg == 0) ? 65536 : int'(length_cfg);
      y.last_in_vector = (vec_position + 1 >= vlen);
      if (y.last_in_vector)
         clear_history();
      else
         vec_position = (vec_position + 1) & 16'hFFFF;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t: %s got %0d expected %0d", $time, what, got, want);
   endtask

   // request side: predict on acceptance at the rising edge
   always @(posedge clock) begin
      rsp_word_type predicted;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         if (filter_word(req_data, predicted))
            expected_outputs.push_back(predicted);
      end
   end

   // request driver: a new word only once the previous one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            req_valid <= 1'b1;
            req_data  <= pending_words.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall, plus one long hold-off during the pressure phase
   always @(negedge clock) begin
      if (hold_phase && !hold_used) begin
         hold_left = HOLD_CYCLES;
         hold_used = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // result checker: oldest expectation against each accepted word
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            report_mismatch("unexpected word, out_re", rsp_data.out_re, 0);
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_data.out_re !== want.out_re)
               report_mismatch("out_re", rsp_data.out_re, want.out_re);
            if (rsp_data.out_im !== want.out_im)
               report_mismatch("out_im", rsp_data.out_im, want.out_im);
            if (rsp_data.last_in_vector !== want.last_in_vector)
               report_mismatch("last_in_vector", rsp_data.last_in_vector,
                               want.last_in_vector);
         end
      end
   end

   task automatic push_tap(input int idx, input logic [15:0] re, input logic [15:0] im);
      req_word_type w;
      w.cmd       = CMD_TAP;
      w.tap_index = TAP_IDX_BITS'(idx);
      w.value_re  = re;
      w.value_im  = im;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic push_sample(input logic [15:0] re, input logic [15:0] im);
      req_word_type w;
      w.cmd       = CMD_SAMPLE;
      w.tap_index = TAP_IDX_BITS'($urandom);
      w.value_re  = re;
      w.value_im  = im;
      pending_words.push_back(w);
      words_queued++;
   endtask

   // register write; the mirror follows the same field masking as the block
   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_TAP_COUNT:     taps_cfg   = data[TAP_COUNT_BITS-1:0];
         REG_VECTOR_LENGTH: length_cfg = data;
         REG_COMPLEX_MODE:  cplx_cfg   = data[0];
         default: ;
      endcase
   endtask

   // wait until every word is taken and every result is back, then let it settle
   task automatic drain_and_settle();
      while (pending_words.size() != 0 || req_valid || expected_outputs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // extremes and zero show up often, the rest is uniform
   function automatic logic [15:0] pick_value();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int tc, len, n;
      clear_history();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: one tap, one-sample vectors, real mode
      // most negative squared saturates, imaginary input is ignored
      push_tap(0, 16'h8000, 16'h7FFF);
      push_sample(16'h8000, 16'h0000);
      push_sample(16'h7FFF, 16'h8000);
      push_tap(0, 16'h7FFF, 16'h8000);
      push_sample(16'h7FFF, 16'h7FFF);
      push_sample(16'h8000, 16'hFFFF);
      drain_and_settle();

      // complex mode, two taps: real part cancels, imaginary part saturates
      write_csr(REG_COMPLEX_MODE, 16'd1);
      write_csr(REG_TAP_COUNT, 16'd2);
      write_csr(REG_VECTOR_LENGTH, 16'd3);
      push_tap(1, 16'h8000, 16'h8000);
      push_tap(0, 16'h8000, 16'h8000);
      push_sample(16'h8000, 16'h8000);
      push_sample(16'h8000, 16'h8000);
      push_sample(16'h8000, 16'h8000);
      push_sample(16'h7FFF, 16'h8000);
      drain_and_settle();

      // zero taps via masked upper bits, and a write past the register list
      write_csr(REG_TAP_COUNT, 16'hFF80);
      write_csr(REG_UNUSED, 16'hFFFF);
      push_sample(16'd1234, -16'sd1234);
      push_sample(16'h7FFF, 16'h7FFF);
      drain_and_settle();

      // load every tap before any wider filter runs
      for (int i = 0; i < MAX_TAPS; i++)
         push_tap(i, pick_value(), pick_value());
      drain_and_settle();

      // tap count above the maximum, zero length meaning a full-size vector
      write_csr(REG_TAP_COUNT, 16'h007F);
      write_csr(REG_VECTOR_LENGTH, 16'd0);
      write_csr(REG_COMPLEX_MODE, 16'd0);
      repeat (5) push_sample(pick_value(), pick_value());
      drain_and_settle();
      // length dropped below the current position ends the vector on the next sample
      write_csr(REG_VECTOR_LENGTH, 16'd2);
      push_sample(16'h7FFF, 16'h7FFF);
      push_sample(16'h8000, 16'h7FFF);
      drain_and_settle();

      // no idling anywhere; the receiver holds off first so the block backs up
      calm       = 1'b1;
      hold_phase = 1'b1;
      write_csr(REG_TAP_COUNT, 16'd4);
      write_csr(REG_VECTOR_LENGTH, 16'd7);
      write_csr(REG_COMPLEX_MODE, 16'd1);
      for (int i = 0; i < 120; i++) begin
         if ($urandom_range(9) == 0)
            push_tap($urandom_range(63), pick_value(), pick_value());
         else
            push_sample(pick_value(), pick_value());
      end
      drain_and_settle();
      calm       = 1'b0;
      hold_phase = 1'b0;

      // random phases; settings change between phases, often mid-vector
      while (words_queued < WORD_TARGET) begin
         if ($urandom_range(2) != 0) begin
            case ($urandom_range(9))
               0: tc = $urandom_range(1);
               1: tc = MAX_TAPS;
               2: tc = $urandom_range(MAX_TAPS + 1, 127);
               3, 4: tc = $urandom_range(17, MAX_TAPS - 1);
               default: tc = $urandom_range(1, 16);
            endcase
            write_csr(REG_TAP_COUNT,
                      {($urandom_range(3) == 0) ? 9'($urandom) : 9'd0, 7'(tc)});
         end
         if ($urandom_range(2) != 0) begin
            case ($urandom_range(9))
               0: len = 0;
               1: len = 65535;
               2: len = $urandom_range(25, 300);
               default: len = $urandom_range(1, 24);
            endcase
            write_csr(REG_VECTOR_LENGTH, 16'(len));
         end
         if ($urandom_range(2) != 0)
            write_csr(REG_COMPLEX_MODE, {15'($urandom), 1'($urandom)});
         if ($urandom_range(7) == 0)
            write_csr(REG_UNUSED, 16'($urandom));
         n = $urandom_range(15, 50);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(7) == 0)
               push_tap($urandom_range(63), pick_value(), pick_value());
            else
               push_sample(pick_value(), pick_value());
         end
         drain_and_settle();
      end

      if (mismatch_count == 0)
         $display("causal_fir_vector_filter: match");
      else
         $display("causal_fir_vector_filter: mismatch");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #5_000_000;
      $display("causal_fir_vector_filter: mismatch");
      $finish;
   end

endmodule

[causal_fir_vector_filter.f]
sv/cfv_pkg.sv
sv/cfv_ctrl.sv
sv/cfv_datapath.sv
sv/causal_fir_vector_filter.sv
tb/sv/causal_fir_vector_filter_tb.sv
